// ----- hw/rtl/jel_pkg.sv -----
// Shared types and constants for the JPEG end locator.
`default_nettype none

package jel_pkg;

  localparam logic [7:0] MarkFf  = 8'hFF;
  localparam logic [7:0] MarkSoi = 8'hD8;
  localparam logic [7:0] MarkSos = 8'hDA;
  localparam logic [7:0] MarkEoi = 8'hD9;

  localparam int unsigned OffsetWidth = 32;

  typedef enum logic [1:0] {
    StFound = 2'd0,
    StBad   = 2'd1,
    StEos   = 2'd2
  } status_e;

  typedef struct packed {
    status_e                status;
    logic [OffsetWidth-1:0] end_offset;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/jel_parser.sv -----
// Byte-serial marker segment walker: phase, counters and one result per file.
`default_nettype none

module jel_parser #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_fire_i,
  input  wire              sof_i,
  input  wire [7:0]        byte_i,
  input  wire              eos_i,
  output logic             res_valid_o,
  output jel_pkg::result_t res_o
);

  typedef enum logic [3:0] {
    PhIdle = 4'd0,
    PhSoi1 = 4'd1,
    PhMark = 4'd2,
    PhFill = 4'd3,
    PhLenH = 4'd4,
    PhLenL = 4'd5,
    PhSkip = 4'd6,
    PhScan = 4'd7
  } phase_e;

  localparam logic [OFFSET_BITS-1:0] CntMax = {OFFSET_BITS{1'b1}};

  phase_e                 phase_q, phase_d;
  logic [15:0]            skip_q, skip_d;
  logic [7:0]             lenh_q, lenh_d;
  logic [OFFSET_BITS-1:0] cnt_q, cnt_d;
  logic                   scan_q, scan_d;
  logic                   pend_q, pend_d;

  logic [OFFSET_BITS-1:0] cnt_inc;
  logic [15:0]            seg_len;
  logic [15:0]            skip_dec;
  logic [63:0]            cnt_wide;
  logic                   cnt_sat;
  logic                   emit;

  assign cnt_inc  = (cnt_q != CntMax) ? cnt_q + OFFSET_BITS'(1) : cnt_q;
  assign seg_len  = {lenh_q, byte_i};
  assign skip_dec = (skip_q != 16'd0) ? skip_q - 16'd1 : 16'd0;
  assign cnt_wide = 64'(cnt_inc);
  // offset field is 32 bits; clamp a wider counter
  assign cnt_sat  = (cnt_wide >> 32) != 64'd0;

  always_comb begin
    phase_d     = phase_q;
    skip_d      = skip_q;
    lenh_d      = lenh_q;
    cnt_d       = cnt_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    emit        = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{status: jel_pkg::StFound, end_offset: '0};

    if (in_fire_i) begin
      if (sof_i) begin
        skip_d = 16'd0;
        lenh_d = 8'd0;
        scan_d = 1'b0;
        pend_d = 1'b0;
        cnt_d  = OFFSET_BITS'(1);
        if (byte_i != jel_pkg::MarkFf) begin
          emit         = 1'b1;
          res_o.status = jel_pkg::StBad;
        end else begin
          phase_d = PhSoi1;
          if (eos_i) begin
            emit         = 1'b1;
            res_o.status = jel_pkg::StEos;
          end
        end
      end else if (phase_q != PhIdle) begin
        cnt_d = cnt_inc;
        case (phase_q)
          PhSoi1: begin
            if (byte_i != jel_pkg::MarkSoi) begin
              emit         = 1'b1;
              res_o.status = jel_pkg::StBad;
            end else begin
              phase_d = PhMark;
            end
          end
          PhMark: begin
            if (byte_i != jel_pkg::MarkFf) begin
              emit         = 1'b1;
              res_o.status = jel_pkg::StBad;
            end else begin
              phase_d = PhFill;
            end
          end
          PhFill: begin
            if (byte_i != jel_pkg::MarkFf) begin
              if (byte_i == jel_pkg::MarkSos) scan_d = 1'b1;
              phase_d = PhLenH;
            end
          end
          PhLenH: begin
            lenh_d  = byte_i;
            phase_d = PhLenL;
          end
          PhLenL: begin
            if (seg_len < 16'd3) begin
              emit         = 1'b1;
              res_o.status = jel_pkg::StBad;
            end else begin
              skip_d  = seg_len - 16'd2;
              phase_d = PhSkip;
            end
          end
          PhSkip: begin
            skip_d = skip_dec;
            if (skip_dec == 16'd0) begin
              pend_d  = 1'b0;
              phase_d = scan_q ? PhScan : PhMark;
            end
          end
          PhScan: begin
            if (pend_q && byte_i == jel_pkg::MarkEoi) begin
              pend_d           = 1'b0;
              emit             = 1'b1;
              res_o.status     = jel_pkg::StFound;
              res_o.end_offset = cnt_sat ? '1 : cnt_wide[31:0];
            end else begin
              pend_d = (byte_i == jel_pkg::MarkFf);
            end
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
        if (!emit && eos_i && phase_q <= PhScan) begin
          emit         = 1'b1;
          res_o.status = jel_pkg::StEos;
        end
      end
    end

    if (emit) begin
      res_valid_o = 1'b1;
      phase_d     = PhIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      skip_q  <= 16'd0;
      lenh_q  <= 8'd0;
      cnt_q   <= '0;
      scan_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      lenh_q  <= lenh_d;
      cnt_q   <= cnt_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
    end
  end

`ifndef ASSERT_OFF
  a_res_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> in_fire_i)
    else $error("result without an input beat");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSkip) |-> (skip_q != 16'd0))
    else $error("skip phase with empty skip count");

  a_fail_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != jel_pkg::StFound) |-> (res_o.end_offset == '0))
    else $error("offset reported on a failed file");

  a_found_min_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == jel_pkg::StFound) |-> (res_o.end_offset >= 32'd9))
    else $error("end marker found too early");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/jel_out_buf.sv -----
// Two-entry result buffer that decouples the parser from the result stream.
`default_nettype none

module jel_out_buf (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  jel_pkg::result_t push_data_i,
  output logic             space_o,
  output logic             valid_o,
  input  wire              ready_i,
  output jel_pkg::result_t data_o
);

  jel_pkg::result_t mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       count_q, count_d;
  logic             pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign space_o = (count_q != 2'd2);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) count_d = count_q + 2'd1;
    else if (!push_i && pop) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      count_q <= count_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd2))
    else $error("result pushed into full buffer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("buffer count out of range");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> (count_q == $past(count_q) - 2'd1))
    else $error("pop did not drain an entry");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/jpeg_end_locator.sv -----
// Top level of the JPEG end locator: byte stream in, one verdict per file out.
//
// Slave stream: one file byte per beat in tdata; tuser marks the first byte of
// a file, tlast the last byte. A first-byte beat always restarts parsing.
// Master stream: one beat per file with status (found, bad format, stream
// ended) and the end offset through the D9 byte (zero unless found).
// Throughput: one byte per cycle while tready is high; each byte updates the phase and
// counters through combinational logic ahead of the state registers.
// Output: the result of the beat that finished the file is registered into the
// buffer and reaches the master side once earlier results have been taken.
// Stall: results land in a two-entry buffer; tready drops only while both
// entries wait to be taken, and rises again the cycle after the master takes one.
// Reset: parser goes idle awaiting a first-byte beat, buffer empties; bytes
// given while idle without the first-byte flag are dropped silently.
// OFFSET_BITS sets the width of the saturating byte counter; the reported
// offset is clamped to 32 bits.
`default_nettype none

module jpeg_end_locator #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire         s_axis_tuser_i,   // [0] start_of_file
  input  wire         s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [1:0] status, [33:2] end_offset, [39:34] zero
);

  logic             in_fire;
  logic             res_valid;
  jel_pkg::result_t res;
  jel_pkg::result_t head;
  logic             space;

  assign s_axis_tready_o = space;
  assign in_fire         = s_axis_tvalid_i && space;

  jel_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .sof_i       (s_axis_tuser_i),
    .byte_i      (s_axis_tdata_i),
    .eos_i       (s_axis_tlast_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  jel_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (head)
  );

  assign m_axis_tdata_o = {6'd0, head.end_offset, head.status};

endmodule

`default_nettype wire

// ----- sim/jel_result_checker.sv -----
// Result checker for the JPEG end locator: predicts each file verdict and compares beats.
`timescale 1ns / 100ps

module jel_result_checker
  import jel_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_tvalid_i,
  input  wire         s_tready_i,
  input  wire  [7:0]  s_tdata_i,   // [7:0] data_byte
  input  wire         s_tuser_i,   // [0] start_of_file
  input  wire         s_tlast_i,
  input  wire         m_tvalid_i,
  input  wire         m_tready_i,
  input  wire  [39:0] m_tdata_i,   // [1:0] status, [33:2] end_offset, [39:34] zero
  output int unsigned errors_o,
  output int unsigned waiting_o
);

  localparam int unsigned MaxReports = 10;

  typedef enum logic [3:0] {
    PhIdle,
    PhSoi,
    PhMarker,
    PhFill,
    PhLenHi,
    PhLenLo,
    PhSkip,
    PhScan
  } phase_e;

  phase_e                 phase;
  logic [15:0]            skip_left;
  logic [7:0]             len_hi;
  logic [OFFSET_BITS-1:0] offset_cnt;
  logic                   in_scan;
  logic                   prev_ff;

  result_t     verdicts_due[$];
  int unsigned err_cnt = 0;

  // Walk one byte through the marker parser; got is set when the file is decided.
  task automatic locate_end(input logic sof, input logic [7:0] b, input logic eos,
                            output logic got, output result_t res);
    logic                   done;
    status_e                st;
    logic [15:0]            seg_len;
    logic [63:0]            wide;
    logic [OffsetWidth-1:0] off;
    done = 1'b0;
    st   = StBad;
    off  = '0;
    if (sof) begin
      skip_left  = '0;
      len_hi     = '0;
      in_scan    = 1'b0;
      prev_ff    = 1'b0;
      offset_cnt = OFFSET_BITS'(1);
      if (b != MarkFf) begin
        done = 1'b1;
      end else begin
        phase = PhSoi;
        if (eos) begin
          done = 1'b1;
          st   = StEos;
        end
      end
    end else if (phase != PhIdle) begin
      if (offset_cnt != '1) offset_cnt = offset_cnt + 1'b1;
      case (phase)
        PhSoi: begin
          if (b != MarkSoi) done = 1'b1;
          else phase = PhMarker;
        end
        PhMarker: begin
          if (b != MarkFf) done = 1'b1;
          else phase = PhFill;
        end
        PhFill: begin
          // extra FF bytes are fill; the first other byte is the marker code
          if (b != MarkFf) begin
            if (b == MarkSos) in_scan = 1'b1;
            phase = PhLenHi;
          end
        end
        PhLenHi: begin
          len_hi = b;
          phase  = PhLenLo;
        end
        PhLenLo: begin
          seg_len = {len_hi, b};
          if (seg_len < 16'd3) begin
            done = 1'b1;
          end else begin
            skip_left = seg_len - 16'd2;
            phase     = PhSkip;
          end
        end
        PhSkip: begin
          if (skip_left != 0) skip_left = skip_left - 1'b1;
          if (skip_left == 0) begin
            prev_ff = 1'b0;
            phase   = in_scan ? PhScan : PhMarker;
          end
        end
        PhScan: begin
          if (prev_ff && b == MarkEoi) begin
            prev_ff = 1'b0;
            done    = 1'b1;
            st      = StFound;
            wide    = 64'(offset_cnt);
            off     = (wide > 64'hFFFF_FFFF) ? '1 : wide[OffsetWidth-1:0];
          end else begin
            prev_ff = (b == MarkFf);
          end
        end
        default: phase = PhIdle;
      endcase
      if (!done && eos) begin
        done = 1'b1;
        st   = StEos;
      end
    end
    if (done) phase = PhIdle;
    got            = done;
    res.status     = st;
    res.end_offset = off;
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    err_cnt++;
    if (err_cnt <= MaxReports)
      $display("[%0t] mismatch %s: expected %0d, got %0d", $time, what, exp_v, act_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t due;
    result_t seen;
    logic    got;
    if (!rst_ni) begin
      phase      = PhIdle;
      skip_left  = '0;
      len_hi     = '0;
      offset_cnt = '0;
      in_scan    = 1'b0;
      prev_ff    = 1'b0;
      verdicts_due.delete();
      waiting_o  <= 0;
      errors_o   <= err_cnt;
    end else begin
      // results on this edge stem from bytes accepted on earlier edges
      if (m_tvalid_i && m_tready_i) begin
        seen.status     = status_e'(m_tdata_i[1:0]);
        seen.end_offset = m_tdata_i[33:2];
        if (verdicts_due.size() == 0) begin
          note_mismatch("unexpected result beat, status", 0, 32'(seen.status));
        end else begin
          due = verdicts_due.pop_front();
          if (seen.status != due.status)
            note_mismatch("status", 32'(due.status), 32'(seen.status));
          if (seen.end_offset != due.end_offset)
            note_mismatch("end_offset", due.end_offset, seen.end_offset);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        locate_end(s_tuser_i, s_tdata_i, s_tlast_i, got, due);
        if (got) verdicts_due.push_back(due);
      end
      waiting_o <= verdicts_due.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the JPEG end locator: builds byte streams, drives them, gives the verdict.
`timescale 1ns / 100ps

module tb;
  import jel_pkg::*;

  localparam int unsigned TargetBeats = 650;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 20;

  typedef struct packed {
    logic       sof;
    logic [7:0] data;
    logic       eos;
  } beat_t;

  typedef enum int {
    FlWell,
    FlBadFirst,
    FlBadSecond,
    FlMissingFf,
    FlShortLen,
    FlCutEos,
    FlCutRestart,
    FlBigLenCut,
    FlNoise
  } flavor_e;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tuser  = 1'b0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  int unsigned errors;
  int unsigned waiting;
  int unsigned cycle_cnt = 0;
  int unsigned rx_left   = 0;

  beat_t       file_bytes[$];
  beat_t       byte_stream[$];
  int unsigned file_byte_total = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  jpeg_end_locator uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  jel_result_checker verdict_chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .s_tlast_i  (s_tlast),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .errors_o   (errors),
    .waiting_o  (waiting)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] any_but(input logic [7:0] a, input logic [7:0] c);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == a || v == c);
    return v;
  endfunction

  function automatic flavor_e pick_flavor();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return FlWell;
    if (r < 65) return FlBadFirst;
    if (r < 70) return FlBadSecond;
    if (r < 75) return FlMissingFf;
    if (r < 80) return FlShortLen;
    if (r < 86) return FlCutEos;
    if (r < 91) return FlCutRestart;
    if (r < 95) return FlBigLenCut;
    return FlNoise;
  endfunction

  task automatic put(input logic [7:0] b);
    beat_t bt;
    bt.sof  = (file_bytes.size() == 0);
    bt.data = b;
    bt.eos  = 1'b0;
    file_bytes.push_back(bt);
  endtask

  task automatic put_random(input int unsigned n);
    repeat (n) put(8'($urandom_range(0, 255)));
  endtask

  task automatic put_marker(input logic [7:0] code);
    int unsigned fills;
    fills = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 3) : 0;
    put(MarkFf);
    repeat (fills) put(MarkFf);
    put(code);
  endtask

  task automatic put_segment(input logic [7:0] code, input int unsigned body);
    logic [15:0] seg_len;
    seg_len = 16'(body + 2);
    put_marker(code);
    put(seg_len[15:8]);
    put(seg_len[7:0]);
    put_random(body);
  endtask

  task automatic build_jpeg();
    int unsigned nseg;
    int unsigned nscan;
    logic [7:0]  code;
    put(MarkFf);
    put(MarkSoi);
    nseg = $urandom_range(0, 2);
    repeat (nseg) begin
      // an early D9 is just another marker with a length
      code = ($urandom_range(0, 9) == 0) ? MarkEoi : any_but(MarkFf, MarkSos);
      put_segment(code, $urandom_range(1, 6));
    end
    put_segment(MarkSos, $urandom_range(1, 4));
    nscan = $urandom_range(0, 12);
    repeat (nscan) begin
      if ($urandom_range(0, 5) == 0) begin
        put(MarkFf);
        put($urandom_range(0, 1) ? 8'h00 : MarkFf);
      end else begin
        put_random(1);
      end
    end
    put(MarkFf);
    if ($urandom_range(0, 2) == 0) put(MarkFf);
    put(MarkEoi);
  endtask

  task automatic flush_file(input logic counted);
    foreach (file_bytes[i]) byte_stream.push_back(file_bytes[i]);
    if (counted) file_byte_total += file_bytes.size();
    file_bytes.delete();
  endtask

  task automatic add_file(input logic [7:0] bytes[$], input logic last_eos);
    foreach (bytes[i]) put(bytes[i]);
    file_bytes[$].eos = last_eos;
    flush_file(1'b1);
  endtask

  task automatic build_random_stream();
    flavor_e     fl;
    int unsigned cut;
    beat_t       bt;
    while (file_byte_total < TargetBeats) begin
      fl = pick_flavor();
      case (fl)
        FlWell: begin
          build_jpeg();
          if ($urandom_range(0, 3) == 0) file_bytes[$].eos = 1'b1;
        end
        FlBadFirst: begin
          build_jpeg();
          file_bytes[0].data = any_but(MarkFf, MarkFf);
        end
        FlBadSecond: begin
          build_jpeg();
          file_bytes[1].data = any_but(MarkSoi, MarkSoi);
        end
        FlMissingFf: begin
          put(MarkFf);
          put(MarkSoi);
          put(any_but(MarkFf, MarkFf));
          put_random($urandom_range(0, 4));
        end
        FlShortLen: begin
          put(MarkFf);
          put(MarkSoi);
          put_marker(any_but(MarkFf, MarkFf));
          put(8'h00);
          put(8'($urandom_range(0, 2)));
          put_random($urandom_range(0, 3));
        end
        FlCutEos, FlCutRestart: begin
          // file broken off early; without end of stream the next start drops it
          build_jpeg();
          cut = $urandom_range(1, file_bytes.size() - 1);
          while (file_bytes.size() > cut) void'(file_bytes.pop_back());
          if (fl == FlCutEos) file_bytes[$].eos = 1'b1;
        end
        FlBigLenCut: begin
          put(MarkFf);
          put(MarkSoi);
          put_marker(any_but(MarkFf, MarkFf));
          put(8'($urandom_range(1, 255)));
          put_random(1);
          put_random($urandom_range(1, 12));
          if ($urandom_range(0, 1) == 1) file_bytes[$].eos = 1'b1;
        end
        default: begin
          repeat ($urandom_range(1, 6)) begin
            bt.sof  = ($urandom_range(0, 7) == 0);
            bt.data = 8'($urandom_range(0, 255));
            bt.eos  = ($urandom_range(0, 5) == 0);
            file_bytes.push_back(bt);
          end
        end
      endcase
      flush_file(1'b1);
      // junk after a finished file is dropped while idle
      if (fl == FlWell && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          bt.sof  = 1'b0;
          bt.data = 8'($urandom_range(0, 255));
          bt.eos  = ($urandom_range(0, 2) == 0);
          file_bytes.push_back(bt);
        end
        flush_file(1'b0);
      end
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
      rx_left  <= 0;
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (m_tready) begin
      m_tready <= 1'b0;
      rx_left  <= pick_gap();
    end else begin
      m_tready <= 1'b1;
      rx_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned gap;
    logic        calm;
    calm = 1'b0;

    // segment with an early D9 code, an FF byte in the scan header, FF FF D9 end
    add_file('{8'hFF, 8'hD8, 8'hFF, 8'hD9, 8'h00, 8'h03, 8'h55, 8'hFF, 8'hDA,
               8'h00, 8'h03, 8'hFF, 8'hFF, 8'hFF, 8'hD9}, 1'b0);
    add_file('{8'h00}, 1'b0);                               // bad first byte
    add_file('{8'hFF, 8'h12}, 1'b0);                        // bad second byte
    add_file('{8'hFF, 8'hD8, 8'h12}, 1'b0);                 // segment FF missing
    add_file('{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h02}, 1'b0);  // length too short
    add_file('{8'hFF}, 1'b1);                               // stream ends on first byte
    build_random_stream();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (byte_stream[i]) begin
      if (i % 80 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= byte_stream[i].data;
      s_tuser  <= byte_stream[i].sof;
      s_tlast  <= byte_stream[i].eos;
      do @(posedge clk); while (!s_tready);
    end
    s_tvalid <= 1'b0;

    // let the checker's count settle before watching it drain
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (errors == 0 && waiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
